FILE: sv/salc_pkg.sv
// shared types and constants for the set-associative tag store core
// no dependencies
package salc_pkg;

  localparam int TAG_W = 62;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS_USED  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

FILE: sv/salc_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/set_assoc_lru_cache_tags_core.sv
// Tag store with LRU replacement. An access reads its set in ST_READ and writes it
// back in ST_UPDATE; its result strobe is registered out of ST_UPDATE, and a modify
// passes through ST_READ and ST_UPDATE again for its second result. busy is low
// only in ST_IDLE, so a new load, store or modify is not taken until the previous
// access is done. After rst a clearing pass empties every set with busy high.
// The receiver cannot stall results.
module set_assoc_lru_cache_tags_core #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [63:0]           address,
  input  logic                  mode,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [5:0]            cfg_data,
  output logic                  result_valid,
  output logic [1:0]            outcome,
  output logic [2:0]            way_used,
  output logic                  last_result,
  output logic [31:0]           hits_total,
  output logic [31:0]           misses_total,
  output logic [31:0]           evictions_total
);
  import salc_pkg::*;

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int SW    = MAX_SET_BITS;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RW    = WW;
  localparam int LINE  = 1 + TAG_W + RW;
  localparam int ROW   = LINE * MAX_WAYS;
  localparam int BLOCK_MAX = 32;

  // configuration registers
  logic [3:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 4'd4;
      block_bits <= 6'd4;
      ways_used  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SET_BITS:   set_bits   <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data;
        CFG_WAYS_USED:  ways_used  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [4:0] s_c;
  logic [5:0] b_c;
  logic [4:0] e_c;
  always_comb begin
    s_c = {1'b0, set_bits};
    if (s_c < 5'd1) s_c = 5'd1;
    if (s_c > 5'(MAX_SET_BITS)) s_c = 5'(MAX_SET_BITS);
    b_c = block_bits;
    if (b_c < 6'd1) b_c = 6'd1;
    if (b_c > 6'(BLOCK_MAX)) b_c = 6'(BLOCK_MAX);
    e_c = {1'b0, ways_used};
    if (e_c < 5'd1) e_c = 5'd1;
    if (e_c > 5'(MAX_WAYS)) e_c = 5'(MAX_WAYS);
  end

  // captured transaction
  logic        mode_q;
  logic        second;
  logic [TAG_W-1:0] tag_q;
  logic [SW-1:0]    set_q;
  state_t state, state_next;
  logic [SW:0] clr_cnt;

  logic [63:0] a_m, tag_full, set_full;
  always_comb begin
    a_m = (ADDR_WIDTH >= 64) ? address : (address & ((64'd1 << ADDR_WIDTH) - 64'd1));
    tag_full = a_m >> (7'(s_c) + 7'(b_c));
    set_full = (a_m >> b_c) & ((64'd1 << s_c) - 64'd1);
  end

  // memory
  logic           ram_we;
  logic [SW-1:0]  ram_waddr, ram_raddr;
  logic [ROW-1:0] ram_wdata, ram_rdata;

  salc_ram #(.WIDTH(ROW), .DEPTH(SETS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // unpack the set and decide
  logic [MAX_WAYS-1:0] v_w;
  logic [TAG_W-1:0]    t_w [MAX_WAYS];
  logic [RW-1:0]       r_w [MAX_WAYS];
  logic                found, free_found;
  logic [WW-1:0]       way;
  logic [RW-1:0]       old_rank;
  logic [ROW-1:0]      row_new;
  outcome_t            oc;

  always_comb begin
    found = 1'b0;
    free_found = 1'b0;
    way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      v_w[w] = ram_rdata[w*LINE + TAG_W + RW];
      t_w[w] = ram_rdata[w*LINE + RW +: TAG_W];
      r_w[w] = ram_rdata[w*LINE +: RW];
    end
    // hit search
    for (int w = MAX_WAYS-1; w >= 0; w--)
      if (5'(w) < e_c && v_w[w] && t_w[w] == tag_q) begin
        found = 1'b1;
        way = WW'(w);
      end
    if (!found) begin
      for (int w = MAX_WAYS-1; w >= 0; w--)
        if (5'(w) < e_c && !v_w[w]) begin
          free_found = 1'b1;
          way = WW'(w);
        end
      if (!free_found) begin
        way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
          if (5'(w) < e_c && r_w[w] > r_w[way]) way = WW'(w);
      end
    end
    oc = found ? OUT_HIT : (free_found ? OUT_FILL : OUT_EVICT);
    old_rank = r_w[way];
    // recency update
    row_new = ram_rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WW'(w) == way) begin
        row_new[w*LINE +: LINE] = {1'b1, tag_q, {RW{1'b0}}};
      end else if (5'(w) < e_c && v_w[w] && (!found || r_w[w] < old_rank)
                   && r_w[w] != RW'(MAX_WAYS-1)) begin
        row_new[w*LINE +: RW] = r_w[w] + RW'(1);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_waddr = set_q;
    ram_wdata = row_new;
    ram_raddr = set_q;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt[SW-1:0];
        ram_wdata = '0;
        if (clr_cnt == (SW+1)'(SETS-1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = ST_READ;
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        ram_we = 1'b1;
        state_next = (mode_q && !second) ? ST_READ : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      second <= 1'b0;
      result_valid <= 1'b0;
      hits_total <= '0;
      misses_total <= '0;
      evictions_total <= '0;
    end else begin
      result_valid <= 1'b0;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_IDLE && start) second <= 1'b0;
      if (state == ST_UPDATE) begin
        second <= 1'b1;
        result_valid <= 1'b1;
        if (oc == OUT_HIT) begin
          if (hits_total != '1) hits_total <= hits_total + 1'b1;
        end else begin
          if (misses_total != '1) misses_total <= misses_total + 1'b1;
          if (oc == OUT_EVICT && evictions_total != '1)
            evictions_total <= evictions_total + 1'b1;
        end
      end
    end
  end

  // payload capture and result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      mode_q <= mode;
      tag_q  <= tag_full[TAG_W-1:0];
      set_q  <= set_full[SW-1:0];
    end
    if (state == ST_UPDATE) begin
      outcome     <= oc;
      way_used    <= 3'(way);
      last_result <= !mode_q || second;
    end
  end
endmodule

FILE: bench/set_assoc_lru_cache_tags_core_chk.sv
// checker for the set-associative tag store: watches the item, config and result ports,
// keeps its own copy of the tag store and compares every result against it
// depends on salc_pkg
`timescale 1ns / 100ps

module set_assoc_lru_cache_tags_core_chk
  import salc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] address,
  input  logic        mode,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        result_valid,
  input  logic [1:0]  outcome,
  input  logic [2:0]  way_used,
  input  logic        last_result,
  input  logic [31:0] hits_total,
  input  logic [31:0] misses_total,
  input  logic [31:0] evictions_total,
  output int          fails,
  output int          pending,
  output int          checked
);

  localparam int SETS  = 256;
  localparam int WAYS  = 8;
  localparam int LINES = SETS * WAYS;

  typedef struct packed {
    outcome_t    oc;
    logic [2:0]  way;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } access_res_t;

  // shadow tag store and totals
  bit          tv[LINES];
  logic [61:0] tt[LINES];
  bit   [2:0]  tr[LINES];
  logic [31:0] n_hit, n_miss, n_evict;
  logic [3:0]  r_sets, r_ways;
  logic [5:0]  r_blk;
  access_res_t lookups_due[$];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  // move a way to most recent, ageing the younger valid ways in use
  function automatic void promote(int base, int nw, int hw, int old_rank);
    for (int w = 0; w < nw; w++)
      if (w != hw && tv[base + w] && tr[base + w] < old_rank && tr[base + w] < WAYS - 1)
        tr[base + w] = tr[base + w] + 1;
    tr[base + hw] = 0;
  endfunction

  function automatic access_res_t lookup(logic [63:0] a, bit last);
    int s, b, nw, base, way;
    bit found, free;
    logic [61:0] tg;
    access_res_t r;
    s  = (r_sets < 1) ? 1 : (r_sets > 8) ? 8 : r_sets;
    b  = (r_blk < 1) ? 1 : (r_blk > 32) ? 32 : r_blk;
    nw = (r_ways < 1) ? 1 : (r_ways > 8) ? 8 : r_ways;
    tg = 62'(a >> (s + b));
    base = int'((a >> b) & ((64'd1 << s) - 1)) * WAYS;
    found = 0; free = 0; way = 0;
    for (int w = 0; w < nw && !found; w++)
      if (tv[base + w] && tt[base + w] == tg) begin
        found = 1; way = w;
      end
    if (found) begin
      r.oc = OUT_HIT;
      n_hit = sat_inc(n_hit);
      promote(base, nw, way, tr[base + way]);
    end else begin
      for (int w = 0; w < nw && !free; w++)
        if (!tv[base + w]) begin
          free = 1; way = w;
        end
      n_miss = sat_inc(n_miss);
      if (free) r.oc = OUT_FILL;
      else begin
        r.oc = OUT_EVICT;
        n_evict = sat_inc(n_evict);
        way = 0;
        for (int w = 1; w < nw; w++)
          if (tr[base + w] > tr[base + way]) way = w;
      end
      tt[base + way] = tg;
      promote(base, nw, way, WAYS);
      tv[base + way] = 1;
    end
    r.way = 3'(way);
    r.last = last;
    r.hits = n_hit;
    r.misses = n_miss;
    r.evicts = n_evict;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (fails < 30)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  assign pending = lookups_due.size();

  always @(posedge clk) begin
    access_res_t e;
    if (rst) begin
      foreach (tv[i]) begin
        tv[i] = 0; tt[i] = '0; tr[i] = 0;
      end
      n_hit = 0; n_miss = 0; n_evict = 0;
      r_sets = 4; r_blk = 4; r_ways = 1;
      lookups_due.delete();
      fails = 0;
      checked = 0;
    end else begin
      // compare the result transaction with the oldest prediction
      if (result_valid) begin
        checked++;
        if (lookups_due.size() == 0)
          report_mismatch("unexpected result", 1, 0);
        else begin
          e = lookups_due.pop_front();
          if (outcome !== e.oc) report_mismatch("outcome", outcome, e.oc);
          if (way_used !== e.way) report_mismatch("way_used", way_used, e.way);
          if (last_result !== e.last) report_mismatch("last_result", last_result, e.last);
          if (hits_total !== e.hits) report_mismatch("hits_total", hits_total, e.hits);
          if (misses_total !== e.misses)
            report_mismatch("misses_total", misses_total, e.misses);
          if (evictions_total !== e.evicts)
            report_mismatch("evictions_total", evictions_total, e.evicts);
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SET_BITS:   r_sets = cfg_data[3:0];
          CFG_BLOCK_BITS: r_blk  = cfg_data;
          CFG_WAYS_USED:  r_ways = cfg_data[3:0];
          default: ;
        endcase
      end
      // accepted item transaction
      if (start && !busy) begin
        if (mode) begin
          lookups_due.push_back(lookup(address, 0));
          lookups_due.push_back(lookup(address, 1));
        end else
          lookups_due.push_back(lookup(address, 1));
      end
    end
  end

endmodule

FILE: bench/set_assoc_lru_cache_tags_core_tb.sv
// testbench top for set_assoc_lru_cache_tags_core: drives items and register writes,
// instantiates the block and its checker, and prints the verdict
// depends on salc_pkg, set_assoc_lru_cache_tags_core and set_assoc_lru_cache_tags_core_chk
`timescale 1ns / 100ps

module set_assoc_lru_cache_tags_core_tb;
  import salc_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] address;
  logic        mode;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        result_valid;
  logic [1:0]  outcome;
  logic [2:0]  way_used;
  logic        last_result;
  logic [31:0] hits_total, misses_total, evictions_total;
  int          fails, pending, checked;

  int idle_pct;
  int items_sent;
  int cur_s, cur_b, cur_w;

  set_assoc_lru_cache_tags_core DUT (.*);
  set_assoc_lru_cache_tags_core_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("set_assoc_lru_cache_tags_core_tb: FAIL");
    $finish;
  end

  // one item transaction; start stays high until the caller lowers it or the task drops it for a random idle gap
  task automatic send_item(logic [63:0] a, logic m);
    start   <= 1;
    address <= a;
    mode    <= m;
    do @(posedge clk); while (busy);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write enable stays high; the caller lowers it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [5:0] v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] s, logic [5:0] b, logic [3:0] w);
    wait_idle();
    write_reg(CFG_SET_BITS, {2'b00, s});
    write_reg(CFG_BLOCK_BITS, b);
    write_reg(CFG_WAYS_USED, {2'b00, w});
    cfg_we <= 0;
    cur_s = (s < 1) ? 1 : (s > 8) ? 8 : s;
    cur_b = (b < 1) ? 1 : (b > 32) ? 32 : b;
    cur_w = (w < 1) ? 1 : (w > 8) ? 8 : w;
  endtask

  // build an address from tag, set and a random block offset under the current layout
  function automatic logic [63:0] build_addr(logic [63:0] tg, int set_no);
    logic [63:0] off;
    off = {$urandom, $urandom} & ((64'd1 << cur_b) - 1);
    return (tg << (cur_s + cur_b)) | (64'(set_no % (1 << cur_s)) << cur_b) | off;
  endfunction

  task automatic random_items(int n);
    logic [63:0] tg;
    for (int i = 0; i < n; i++) begin
      if (items_sent < 380) idle_pct = 31;
      else if (items_sent < 760) idle_pct = 80;
      else idle_pct = 0;
      if ($urandom_range(99) < 15)
        send_item({$urandom, $urandom}, $urandom_range(1));
      else begin
        // small tag pool on few sets so hits, fills and evictions all occur
        tg = $urandom_range(cur_w + 2);
        if ($urandom_range(9) == 0) tg = tg | ({$urandom, $urandom} << 8);
        send_item(build_addr(tg, $urandom_range(3)), $urandom_range(1));
      end
    end
  endtask

  initial begin
    rst = 1; start = 0; address = '0; mode = 0;
    cfg_we = 0; cfg_index = CFG_SET_BITS; cfg_data = '0;
    idle_pct = 0; items_sent = 0;
    cur_s = 4; cur_b = 4; cur_w = 1;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed, reset layout with one way
    send_item(64'd0, 0);
    send_item(64'd0, 0);
    send_item(64'd0, 1);
    send_item('1, 1);
    send_item(64'h100, 0);
    send_item(64'h0, 1);
    send_item(64'h8000_0000_0000_0000, 0);

    // directed, four ways: fill all, re-touch, then evict
    set_config(4'd2, 6'd3, 4'd4);
    for (int t = 0; t < 4; t++) send_item(build_addr(64'(t), 0), 0);
    send_item(build_addr(64'd1, 0), 0);
    send_item(build_addr(64'd4, 0), 1);
    send_item(build_addr(64'd5, 0), 0);
    send_item(build_addr(64'd0, 0), 1);
    // directed, out-of-range register values and widest layout
    set_config(4'd0, 6'd0, 4'd0);
    send_item('1, 1);
    send_item(64'h5555_5555_5555_5555, 0);
    set_config(4'd15, 6'd63, 4'd15);
    send_item('1, 0);
    send_item('1, 1);
    send_item(64'h0, 0);

    // random phases across several layouts, ways shrinking leaves stale ranks
    set_config(4'd8, 6'd32, 4'd8);  random_items(160);
    set_config(4'd1, 6'd1, 4'd1);   random_items(140);
    set_config(4'd3, 6'd6, 4'd4);   random_items(180);
    set_config(4'd3, 6'd6, 4'd2);   random_items(150);
    set_config(4'd2, 6'd10, 4'd7);  random_items(170);
    set_config(4'd12, 6'd40, 4'd9); random_items(150);
    set_config(4'd5, 6'd17, 4'd3);  random_items(200);

    wait_idle();
    $display("covered %0d items and %0d result transactions over eleven register layouts",
             items_sent, checked);
    if (fails == 0)
      $display("set_assoc_lru_cache_tags_core_tb: PASS");
    else
      $display("set_assoc_lru_cache_tags_core_tb: FAIL");
    $finish;
  end

endmodule
